// ===== rtl/vsat_pkg.sv =====
`default_nettype none

package vsat_pkg;

    localparam int RECORDS = 16;
    localparam int SLOT_W  = (RECORDS > 1) ? $clog2(RECORDS) : 1;
    localparam int CNT_W   = $clog2(RECORDS + 1);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_EN_LOCAL    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EN_DEDUP    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_MS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HEART_HIGH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HEART_LOW   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BREATH_HIGH = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_BREATH_LOW  = 3'd6;

    localparam logic        RST_EN_LOCAL    = 1'b1;
    localparam logic        RST_EN_DEDUP    = 1'b1;
    localparam int          RST_WINDOW_MS   = 60000;
    localparam logic [31:0] RST_WINDOW_S    = 32'(RST_WINDOW_MS / 1000);
    localparam logic [7:0]  RST_HEART_HIGH  = 8'd120;
    localparam logic [7:0]  RST_HEART_LOW   = 8'd40;
    localparam logic [7:0]  RST_BREATH_HIGH = 8'd30;
    localparam logic [7:0]  RST_BREATH_LOW  = 8'd8;

    // floor(x / 1000) = (x * DIV1000_MUL) >> DIV1000_SHIFT for any 32-bit x
    localparam logic [31:0] DIV1000_MUL   = 32'd274877907;
    localparam int          DIV1000_SHIFT = 38;

    localparam logic [2:0] MODE_HEART  = 3'd0;
    localparam logic [2:0] MODE_BREATH = 3'd1;
    localparam logic [2:0] MODE_MOVE   = 3'd2;
    localparam logic [2:0] MODE_TRIG   = 3'd3;
    localparam logic [2:0] MODE_ACK    = 3'd4;
    localparam logic [2:0] MODE_CLR    = 3'd5;
    localparam logic [2:0] MODE_CLRALL = 3'd6;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_INVALID = 2'd1;
    localparam logic [1:0] STAT_FULL    = 2'd2;

    localparam logic [1:0] REC_IDLE = 2'd0;
    localparam logic [1:0] REC_TRIG = 2'd1;
    localparam logic [1:0] REC_ACK  = 2'd2;
    localparam logic [1:0] REC_CLR  = 2'd3;

    localparam logic [2:0] OP_NONE   = 3'd0;
    localparam logic [2:0] OP_RAISE  = 3'd1;
    localparam logic [2:0] OP_ACK    = 3'd2;
    localparam logic [2:0] OP_CLR    = 3'd3;
    localparam logic [2:0] OP_CLRALL = 3'd4;

    localparam logic [3:0] TYPE_NONE        = 4'd0;
    localparam logic [3:0] TYPE_HEART_HIGH  = 4'd1;
    localparam logic [3:0] TYPE_HEART_LOW   = 4'd2;
    localparam logic [3:0] TYPE_BREATH_HIGH = 4'd3;
    localparam logic [3:0] TYPE_BREATH_LOW  = 4'd4;
    localparam logic [3:0] TYPE_NO_MOVE     = 4'd5;
    localparam logic [3:0] TYPE_MAX         = 4'd8;

    localparam logic [1:0] LVL_WARN = 2'd1;
    localparam logic [1:0] LVL_CRIT = 2'd2;

    // broadcast to every cell for the whole item
    typedef struct packed {
        logic [2:0]        op;
        logic [SLOT_W-1:0] slot;
        logic [3:0]        atype;
        logic [1:0]        level;
        logic [7:0]        value;
        logic [31:0]       now;
        logic [31:0]       win;
    } cell_cmd_t;

    // token passed cell to cell
    typedef struct packed {
        logic              valid;
        logic              dup;
        logic              found;
        logic [SLOT_W-1:0] slot;
        logic [CNT_W-1:0]  cnt;
    } scan_t;

endpackage

`default_nettype wire

// ===== rtl/vsat_req_if.sv =====
`default_nettype none

interface vsat_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  mode;
    logic [7:0]  sample_value;
    logic [3:0]  trig_kind;
    logic [1:0]  trig_level;
    logic [7:0]  alarm_index;
    logic [31:0] now_seconds;

    modport source (
        output valid, mode, sample_value, trig_kind, trig_level, alarm_index, now_seconds,
        input  ready
    );
    modport sink (
        input  valid, mode, sample_value, trig_kind, trig_level, alarm_index, now_seconds,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/vsat_rsp_if.sv =====
`default_nettype none

interface vsat_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic        raised;
    logic        dedup_hit;
    logic [7:0]  raised_slot;
    logic [3:0]  raised_type;
    logic [1:0]  raised_level;
    logic [7:0]  raised_value;
    logic [31:0] raised_time;
    logic        local_active;
    logic [31:0] trig_total;
    logic [31:0] ack_total;
    logic [31:0] clear_total;

    modport source (
        output valid, status, raised, dedup_hit, raised_slot, raised_type, raised_level,
               raised_value, raised_time, local_active, trig_total,
               ack_total, clear_total,
        input  ready
    );
    modport sink (
        input  valid, status, raised, dedup_hit, raised_slot, raised_type, raised_level,
               raised_value, raised_time, local_active, trig_total,
               ack_total, clear_total,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/vsat_cell.sv =====
`default_nettype none

module vsat_cell (
    input  logic                            clk,
    input  logic                            rst_n,
    input  vsat_pkg::cell_cmd_t             cmd,
    input  logic                            wr,
    input  logic [vsat_pkg::SLOT_W-1:0]     slot_id,
    input  vsat_pkg::scan_t                 scan_in,
    output vsat_pkg::scan_t                 scan_out
);
    import vsat_pkg::*;

    logic [1:0]  rec_state_reg, rec_state_next;
    logic [3:0]  rec_type_reg;
    logic [1:0]  rec_level_reg;
    logic [7:0]  rec_value_reg;
    logic [31:0] rec_time_reg;
    scan_t       scan_reg, scan_next;

    logic [31:0] age;
    logic        mine;
    logic        match;
    logic        free;
    logic        hit;

    always_comb
    begin
        mine  = (cmd.slot == slot_id);
        age   = cmd.now - rec_time_reg;
        match = (rec_state_reg == REC_TRIG) && (rec_type_reg == cmd.atype) && (age < cmd.win);
        free  = (rec_state_reg == REC_IDLE) || (rec_state_reg == REC_CLR);
        hit   = 1'b0;
        rec_state_next = rec_state_reg;
        scan_next      = scan_in;
        if (scan_in.valid)
        begin
            case (cmd.op)
                OP_RAISE:
                begin
                    if (match)
                    begin
                        scan_next.dup = 1'b1;
                    end
                    if (!scan_in.found && free)
                    begin
                        scan_next.found = 1'b1;
                        scan_next.slot  = slot_id;
                    end
                end
                OP_ACK:
                begin
                    if (mine && rec_state_reg == REC_TRIG)
                    begin
                        hit            = 1'b1;
                        rec_state_next = REC_ACK;
                    end
                end
                OP_CLR:
                begin
                    if (mine && rec_state_reg != REC_CLR)
                    begin
                        hit            = 1'b1;
                        rec_state_next = REC_CLR;
                    end
                end
                OP_CLRALL:
                begin
                    if (rec_state_reg != REC_CLR)
                    begin
                        hit            = 1'b1;
                        rec_state_next = REC_CLR;
                    end
                end
                default:
                begin
                end
            endcase
        end
        if (hit)
        begin
            scan_next.cnt = scan_in.cnt + CNT_W'(1);
        end
        if (wr && mine)
        begin
            rec_state_next = REC_TRIG;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rec_state_reg <= REC_IDLE;
            scan_reg      <= '0;
        end
        else
        begin
            rec_state_reg <= rec_state_next;
            scan_reg      <= scan_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr && mine)
        begin
            rec_type_reg  <= cmd.atype;
            rec_level_reg <= cmd.level;
            rec_value_reg <= cmd.value;
            rec_time_reg  <= cmd.now;
        end
    end

    assign scan_out = scan_reg;

endmodule

`default_nettype wire

// ===== rtl/vital_sign_alarm_table_unit.sv =====
// Channel  Modport  Direction  Word
// req      sink     in         mode, sample, type, level, index, time
// rsp      source   out        status, raised record, counters
// cfg      -        in         cfg_we / cfg_idx / cfg_data, write only
//
// One item at a time. A raise that stores a record goes from S_SCAN through
// S_APPLY to S_DONE, other table ops from S_SCAN to S_DONE, no-ops straight to
// S_DONE; the token walks the row of RECORDS record cells one cell per cycle.
// rsp is registered, so the next word is taken while a result waits. rst_n clears every record to idle.
`default_nettype none

module vital_sign_alarm_table_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    vsat_req_if.sink                          req,
    vsat_rsp_if.source                        rsp,
    input  logic                              cfg_we,
    input  logic [vsat_pkg::CFG_IDX_W-1:0]    cfg_idx,
    input  logic [vsat_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import vsat_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_APPLY = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]  state_reg, state_next;
    cell_cmd_t   cmd_reg, cmd_next;
    logic        start_reg, start_next;
    logic        wr_reg, wr_next;
    logic [1:0]  status_reg, status_next;
    logic        res_raised_reg, res_raised_next;
    logic        res_dup_reg, res_dup_next;

    logic [31:0] cnt_trig_reg, cnt_trig_next;
    logic [31:0] cnt_ack_reg, cnt_ack_next;
    logic [31:0] cnt_clr_reg, cnt_clr_next;
    logic [31:0] last_time_reg, last_time_next;
    logic        local_reg, local_next;

    logic        en_local_reg, en_local_next;
    logic        en_dedup_reg, en_dedup_next;
    logic [31:0] win_reg, win_next;
    logic [7:0]  heart_high_reg, heart_high_next;
    logic [7:0]  heart_low_reg, heart_low_next;
    logic [7:0]  breath_high_reg, breath_high_next;
    logic [7:0]  breath_low_reg, breath_low_next;

    logic        out_valid_reg, out_valid_next;
    logic [1:0]  out_status_reg, out_status_next;
    logic        out_raised_reg, out_raised_next;
    logic        out_dup_reg, out_dup_next;
    logic [7:0]  out_slot_reg, out_slot_next;
    logic [3:0]  out_type_reg, out_type_next;
    logic [1:0]  out_level_reg, out_level_next;
    logic [7:0]  out_value_reg, out_value_next;
    logic [31:0] out_time_reg, out_time_next;
    logic        out_local_reg, out_local_next;
    logic [31:0] out_trig_reg, out_trig_next;
    logic [31:0] out_ack_reg, out_ack_next;
    logic [31:0] out_clr_reg, out_clr_next;

    logic [63:0]       win_prod;
    logic [2:0]        dec_op;
    logic [1:0]        dec_status;
    logic [3:0]        dec_type;
    logic [1:0]        dec_level;
    logic [7:0]        dec_value;
    logic              idx_bad;
    scan_t             head_tok;
    scan_t             chain [RECORDS+1];
    scan_t             tail;

    assign win_prod = 64'(cfg_data) * 64'(DIV1000_MUL);
    assign idx_bad  = ({1'b0, req.alarm_index} >= 9'(RECORDS));

    always_comb
    begin
        dec_op     = OP_NONE;
        dec_status = STAT_OK;
        dec_type   = TYPE_NONE;
        dec_level  = 2'd0;
        dec_value  = req.sample_value;
        case (req.mode)
            MODE_HEART:
            begin
                if (req.sample_value > heart_high_reg)
                begin
                    dec_op    = OP_RAISE;
                    dec_type  = TYPE_HEART_HIGH;
                    dec_level = LVL_WARN;
                end
                else if (req.sample_value != 8'd0 && req.sample_value < heart_low_reg)
                begin
                    dec_op    = OP_RAISE;
                    dec_type  = TYPE_HEART_LOW;
                    dec_level = LVL_CRIT;
                end
            end
            MODE_BREATH:
            begin
                if (req.sample_value > breath_high_reg)
                begin
                    dec_op    = OP_RAISE;
                    dec_type  = TYPE_BREATH_HIGH;
                    dec_level = LVL_WARN;
                end
                else if (req.sample_value != 8'd0 && req.sample_value < breath_low_reg)
                begin
                    dec_op    = OP_RAISE;
                    dec_type  = TYPE_BREATH_LOW;
                    dec_level = LVL_CRIT;
                end
            end
            MODE_MOVE:
            begin
                if (req.sample_value == 8'd0)
                begin
                    dec_op    = OP_RAISE;
                    dec_type  = TYPE_NO_MOVE;
                    dec_level = LVL_WARN;
                end
            end
            MODE_TRIG:
            begin
                if (req.trig_kind == TYPE_NONE || req.trig_kind > TYPE_MAX)
                begin
                    dec_status = STAT_INVALID;
                end
                else
                begin
                    dec_op    = OP_RAISE;
                    dec_type  = req.trig_kind;
                    dec_level = req.trig_level;
                end
            end
            MODE_ACK:
            begin
                if (idx_bad)
                begin
                    dec_status = STAT_INVALID;
                end
                else
                begin
                    dec_op = OP_ACK;
                end
            end
            MODE_CLR:
            begin
                if (idx_bad)
                begin
                    dec_status = STAT_INVALID;
                end
                else
                begin
                    dec_op = OP_CLR;
                end
            end
            MODE_CLRALL:
            begin
                dec_op = OP_CLRALL;
            end
            default:
            begin
                dec_status = STAT_INVALID;
            end
        endcase
    end

    always_comb
    begin
        head_tok       = '0;
        head_tok.valid = start_reg;
    end

    assign chain[0] = head_tok;
    assign tail     = chain[RECORDS];

    for (genvar g = 0; g < RECORDS; g++)
    begin : g_cell
        vsat_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cmd      (cmd_reg),
            .wr       (wr_reg),
            .slot_id  (SLOT_W'(g)),
            .scan_in  (chain[g]),
            .scan_out (chain[g+1])
        );
    end

    always_comb
    begin
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        start_next       = 1'b0;
        wr_next          = wr_reg;
        status_next      = status_reg;
        res_raised_next  = res_raised_reg;
        res_dup_next     = res_dup_reg;
        cnt_trig_next    = cnt_trig_reg;
        cnt_ack_next     = cnt_ack_reg;
        cnt_clr_next     = cnt_clr_reg;
        last_time_next   = last_time_reg;
        local_next       = local_reg;
        en_local_next    = en_local_reg;
        en_dedup_next    = en_dedup_reg;
        win_next         = win_reg;
        heart_high_next  = heart_high_reg;
        heart_low_next   = heart_low_reg;
        breath_high_next = breath_high_reg;
        breath_low_next  = breath_low_reg;
        out_valid_next   = out_valid_reg & ~rsp.ready;
        out_status_next  = out_status_reg;
        out_raised_next  = out_raised_reg;
        out_dup_next     = out_dup_reg;
        out_slot_next    = out_slot_reg;
        out_type_next    = out_type_reg;
        out_level_next   = out_level_reg;
        out_value_next   = out_value_reg;
        out_time_next    = out_time_reg;
        out_local_next   = out_local_reg;
        out_trig_next    = out_trig_reg;
        out_ack_next     = out_ack_reg;
        out_clr_next     = out_clr_reg;

        if (cfg_we)
        begin
            case (cfg_idx)
                CFG_EN_LOCAL:    en_local_next    = cfg_data[0];
                CFG_EN_DEDUP:    en_dedup_next    = cfg_data[0];
                CFG_WINDOW_MS:   win_next         = 32'(win_prod >> DIV1000_SHIFT);
                CFG_HEART_HIGH:  heart_high_next  = cfg_data[7:0];
                CFG_HEART_LOW:   heart_low_next   = cfg_data[7:0];
                CFG_BREATH_HIGH: breath_high_next = cfg_data[7:0];
                CFG_BREATH_LOW:  breath_low_next  = cfg_data[7:0];
                default:
                begin
                end
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    cmd_next.op     = dec_op;
                    cmd_next.slot   = req.alarm_index[SLOT_W-1:0];
                    cmd_next.atype  = dec_type;
                    cmd_next.level  = dec_level;
                    cmd_next.value  = dec_value;
                    cmd_next.now    = req.now_seconds;
                    cmd_next.win    = win_reg;
                    status_next     = dec_status;
                    res_raised_next = 1'b0;
                    res_dup_next    = 1'b0;
                    if (dec_op == OP_NONE)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        start_next = 1'b1;
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (tail.valid)
                begin
                    state_next = S_DONE;
                    case (cmd_reg.op)
                        OP_RAISE:
                        begin
                            if (en_dedup_reg && tail.dup)
                            begin
                                res_dup_next = 1'b1;
                            end
                            else if (!tail.found)
                            begin
                                status_next = STAT_FULL;
                            end
                            else
                            begin
                                wr_next         = 1'b1;
                                cmd_next.slot   = tail.slot;
                                res_raised_next = 1'b1;
                                cnt_trig_next   = cnt_trig_reg + 32'd1;
                                last_time_next  = cmd_reg.now;
                                local_next      = local_reg | en_local_reg;
                                state_next      = S_APPLY;
                            end
                        end
                        OP_ACK:
                        begin
                            cnt_ack_next = cnt_ack_reg + 32'(tail.cnt);
                        end
                        OP_CLR, OP_CLRALL:
                        begin
                            cnt_clr_next = cnt_clr_reg + 32'(tail.cnt);
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_APPLY:
            begin
                wr_next    = 1'b0;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_raised_next = res_raised_reg;
                    out_dup_next    = res_dup_reg;
                    out_slot_next   = res_raised_reg ? 8'(cmd_reg.slot) : 8'd0;
                    out_type_next   = res_raised_reg ? cmd_reg.atype : 4'd0;
                    out_level_next  = res_raised_reg ? cmd_reg.level : 2'd0;
                    out_value_next  = res_raised_reg ? cmd_reg.value : 8'd0;
                    out_time_next   = last_time_reg;
                    out_local_next  = local_reg;
                    out_trig_next   = cnt_trig_reg;
                    out_ack_next    = cnt_ack_reg;
                    out_clr_next    = cnt_clr_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            start_reg       <= 1'b0;
            wr_reg          <= 1'b0;
            out_valid_reg   <= 1'b0;
            cnt_trig_reg    <= '0;
            cnt_ack_reg     <= '0;
            cnt_clr_reg     <= '0;
            last_time_reg   <= '0;
            local_reg       <= 1'b0;
            en_local_reg    <= RST_EN_LOCAL;
            en_dedup_reg    <= RST_EN_DEDUP;
            win_reg         <= RST_WINDOW_S;
            heart_high_reg  <= RST_HEART_HIGH;
            heart_low_reg   <= RST_HEART_LOW;
            breath_high_reg <= RST_BREATH_HIGH;
            breath_low_reg  <= RST_BREATH_LOW;
        end
        else
        begin
            state_reg       <= state_next;
            start_reg       <= start_next;
            wr_reg          <= wr_next;
            out_valid_reg   <= out_valid_next;
            cnt_trig_reg    <= cnt_trig_next;
            cnt_ack_reg     <= cnt_ack_next;
            cnt_clr_reg     <= cnt_clr_next;
            last_time_reg   <= last_time_next;
            local_reg       <= local_next;
            en_local_reg    <= en_local_next;
            en_dedup_reg    <= en_dedup_next;
            win_reg         <= win_next;
            heart_high_reg  <= heart_high_next;
            heart_low_reg   <= heart_low_next;
            breath_high_reg <= breath_high_next;
            breath_low_reg  <= breath_low_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        status_reg     <= status_next;
        res_raised_reg <= res_raised_next;
        res_dup_reg    <= res_dup_next;
        out_status_reg <= out_status_next;
        out_raised_reg <= out_raised_next;
        out_dup_reg    <= out_dup_next;
        out_slot_reg   <= out_slot_next;
        out_type_reg   <= out_type_next;
        out_level_reg  <= out_level_next;
        out_value_reg  <= out_value_next;
        out_time_reg   <= out_time_next;
        out_local_reg  <= out_local_next;
        out_trig_reg   <= out_trig_next;
        out_ack_reg    <= out_ack_next;
        out_clr_reg    <= out_clr_next;
    end

    assign req.ready        = (state_reg == S_IDLE);
    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.raised       = out_raised_reg;
    assign rsp.dedup_hit    = out_dup_reg;
    assign rsp.raised_slot  = out_slot_reg;
    assign rsp.raised_type  = out_type_reg;
    assign rsp.raised_level = out_level_reg;
    assign rsp.raised_value = out_value_reg;
    assign rsp.raised_time  = out_time_reg;
    assign rsp.local_active = out_local_reg;
    assign rsp.trig_total   = out_trig_reg;
    assign rsp.ack_total    = out_ack_reg;
    assign rsp.clear_total  = out_clr_reg;

`ifndef SYNTHESIS
    a_wr_only_apply: assert property (@(posedge clk) disable iff (!rst_n)
        wr_reg |-> state_reg == S_APPLY)
        else $error("record write outside apply step");

    a_tail_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        tail.valid |-> state_reg == S_SCAN)
        else $error("scan token left the row outside a scan");

    a_apply_raised: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_APPLY |-> res_raised_reg && $past(state_reg) == S_SCAN)
        else $error("apply step without a raised record");

    a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && (!out_valid_reg || rsp.ready))
            |=> rsp.valid && state_reg == S_IDLE)
        else $error("finished word not loaded into output register");
`endif

endmodule

`default_nettype wire

// ===== dv/vital_sign_alarm_table_unit_test.sv =====
`timescale 1ns / 100ps

module vital_sign_alarm_table_unit_test;
    import vsat_pkg::*;

    localparam logic [2:0] MODE_UNUSED   = 3'd7;
    localparam int         DIRECTED_ROWS = 25;
    localparam int         PHASES        = 6;
    localparam int         PHASE_WORDS   = 75;
    localparam int         SETTLE_CYCLES = RECORDS + 8;
    localparam int         IDLE_LIMIT    = 2000;

    typedef struct packed {
        logic [2:0]  mode;
        logic [7:0]  sample_value;
        logic [3:0]  trig_kind;
        logic [1:0]  trig_level;
        logic [7:0]  alarm_index;
        logic [31:0] now_seconds;
    } alarm_word_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        raised;
        logic        dedup_hit;
        logic [7:0]  raised_slot;
        logic [3:0]  raised_type;
        logic [1:0]  raised_level;
        logic [7:0]  raised_value;
        logic [31:0] raised_time;
        logic        local_active;
        logic [31:0] trig_total;
        logic [31:0] ack_total;
        logic [31:0] clear_total;
    } alarm_result_t;

    typedef struct packed {
        logic [2:0]  mode;
        logic [7:0]  sample_value;
        logic [3:0]  trig_kind;
        logic [1:0]  trig_level;
        logic [7:0]  alarm_index;
        logic [31:0] now_seconds;
        logic        typed;
        logic [1:0]  status;
        logic        raised;
        logic        dedup_hit;
    } directed_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    vsat_req_if req_ch();
    vsat_rsp_if rsp_ch();

    vital_sign_alarm_table_unit i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req_ch),
        .rsp      (rsp_ch),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data)
    );

    always #6 clk = ~clk;

    // mirror of the alarm table
    logic        mirror_en_local;
    logic        mirror_en_dedup;
    logic [31:0] mirror_window_ms;
    logic [7:0]  mirror_heart_high;
    logic [7:0]  mirror_heart_low;
    logic [7:0]  mirror_breath_high;
    logic [7:0]  mirror_breath_low;
    logic [3:0]  mirror_type  [RECORDS];
    logic [1:0]  mirror_state [RECORDS];
    logic [1:0]  mirror_level [RECORDS];
    logic [7:0]  mirror_value [RECORDS];
    logic [31:0] mirror_time  [RECORDS];
    logic [31:0] mirror_triggered;
    logic [31:0] mirror_acknowledged;
    logic [31:0] mirror_cleared;
    logic [31:0] mirror_last_time;
    logic        mirror_local;

    alarm_result_t pending_alarm_results[$];

    int          mismatches   = 0;
    int          words_sent   = 0;
    int          results_seen = 0;
    int          raised_seen  = 0;
    int          dedup_seen   = 0;
    int          full_seen    = 0;
    int          invalid_seen = 0;
    int          burst_left   = 0;
    int          stall_left   = 0;
    logic [1:0]  stall_kind   = 2'd0;
    int          idle_cycles  = 0;
    logic [31:0] time_cursor  = 32'd0;

    directed_row_t directed_rows [DIRECTED_ROWS] = '{
        '{MODE_UNUSED, 8'd0,   TYPE_NONE, 2'd0, 8'd0,   32'd0,         1'b1, STAT_INVALID, 1'b0, 1'b0},
        '{MODE_ACK,    8'd0,   TYPE_NONE, 2'd0, 8'd255, 32'd0,         1'b1, STAT_INVALID, 1'b0, 1'b0},
        '{MODE_CLR,    8'd0,   TYPE_NONE, 2'd0, 8'd16,  32'd0,         1'b1, STAT_INVALID, 1'b0, 1'b0},
        '{MODE_TRIG,   8'd7,   TYPE_NONE, 2'd1, 8'd0,   32'd1,         1'b1, STAT_INVALID, 1'b0, 1'b0},
        '{MODE_TRIG,   8'd7,   4'hF,      2'd1, 8'd0,   32'd1,         1'b1, STAT_INVALID, 1'b0, 1'b0},
        '{MODE_TRIG,   8'd7,   4'd9,      2'd1, 8'd0,   32'd1,         1'b1, STAT_INVALID, 1'b0, 1'b0},
        '{MODE_HEART,  8'd0,   TYPE_NONE, 2'd0, 8'd0,   32'd2,         1'b1, STAT_OK,      1'b0, 1'b0},
        '{MODE_HEART,  8'd255, TYPE_NONE, 2'd0, 8'd0,   32'hFFFF_FFF0, 1'b1, STAT_OK,      1'b1, 1'b0},
        '{MODE_HEART,  8'd200, TYPE_NONE, 2'd0, 8'd0,   32'd0,         1'b1, STAT_OK,      1'b0, 1'b1},
        '{MODE_HEART,  8'd1,   TYPE_NONE, 2'd0, 8'd0,   32'd5,         1'b0, STAT_OK,      1'b0, 1'b0},
        '{MODE_HEART,  8'd120, TYPE_NONE, 2'd0, 8'd0,   32'd6,         1'b1, STAT_OK,      1'b0, 1'b0},
        '{MODE_HEART,  8'd40,  TYPE_NONE, 2'd0, 8'd0,   32'd6,         1'b1, STAT_OK,      1'b0, 1'b0},
        '{MODE_BREATH, 8'd255, TYPE_NONE, 2'd0, 8'd0,   32'd7,         1'b0, STAT_OK,      1'b0, 1'b0},
        '{MODE_BREATH, 8'd1,   TYPE_NONE, 2'd0, 8'd0,   32'd8,         1'b0, STAT_OK,      1'b0, 1'b0},
        '{MODE_BREATH, 8'd0,   TYPE_NONE, 2'd0, 8'd0,   32'd8,         1'b1, STAT_OK,      1'b0, 1'b0},
        '{MODE_MOVE,   8'd0,   TYPE_NONE, 2'd0, 8'd0,   32'd9,         1'b0, STAT_OK,      1'b0, 1'b0},
        '{MODE_MOVE,   8'd255, TYPE_NONE, 2'd0, 8'd0,   32'd9,         1'b1, STAT_OK,      1'b0, 1'b0},
        '{MODE_TRIG,   8'd255, TYPE_MAX,  2'd3, 8'd0,   32'hFFFF_FFFF, 1'b0, STAT_OK,      1'b0, 1'b0},
        '{MODE_ACK,    8'd0,   TYPE_NONE, 2'd0, 8'd0,   32'd10,        1'b0, STAT_OK,      1'b0, 1'b0},
        '{MODE_ACK,    8'd0,   TYPE_NONE, 2'd0, 8'd0,   32'd11,        1'b0, STAT_OK,      1'b0, 1'b0},
        '{MODE_CLR,    8'd0,   TYPE_NONE, 2'd0, 8'd15,  32'd12,        1'b0, STAT_OK,      1'b0, 1'b0},
        '{MODE_CLR,    8'd0,   TYPE_NONE, 2'd0, 8'd15,  32'd13,        1'b0, STAT_OK,      1'b0, 1'b0},
        '{MODE_CLRALL, 8'd0,   TYPE_NONE, 2'd0, 8'd0,   32'd14,        1'b0, STAT_OK,      1'b0, 1'b0},
        '{MODE_TRIG,   8'd0,   4'd6,      2'd0, 8'd0,   32'd100,       1'b0, STAT_OK,      1'b0, 1'b0},
        '{MODE_ACK,    8'd0,   TYPE_NONE, 2'd0, 8'd15,  32'd101,       1'b0, STAT_OK,      1'b0, 1'b0}
    };

    function automatic void reset_mirror();
        mirror_en_local     = RST_EN_LOCAL;
        mirror_en_dedup     = RST_EN_DEDUP;
        mirror_window_ms    = 32'(RST_WINDOW_MS);
        mirror_heart_high   = RST_HEART_HIGH;
        mirror_heart_low    = RST_HEART_LOW;
        mirror_breath_high  = RST_BREATH_HIGH;
        mirror_breath_low   = RST_BREATH_LOW;
        for (int i = 0; i < RECORDS; i++)
        begin
            mirror_type[i]  = TYPE_NONE;
            mirror_state[i] = REC_IDLE;
            mirror_level[i] = 2'd0;
            mirror_value[i] = 8'd0;
            mirror_time[i]  = 32'd0;
        end
        mirror_triggered    = 32'd0;
        mirror_acknowledged = 32'd0;
        mirror_cleared      = 32'd0;
        mirror_last_time    = 32'd0;
        mirror_local        = 1'b0;
    endfunction

    function automatic void set_mirror_register(input logic [CFG_IDX_W-1:0] idx,
                                                input logic [31:0] data);
        case (idx)
            CFG_EN_LOCAL:    mirror_en_local    = data[0];
            CFG_EN_DEDUP:    mirror_en_dedup    = data[0];
            CFG_WINDOW_MS:   mirror_window_ms   = data;
            CFG_HEART_HIGH:  mirror_heart_high  = data[7:0];
            CFG_HEART_LOW:   mirror_heart_low   = data[7:0];
            CFG_BREATH_HIGH: mirror_breath_high = data[7:0];
            CFG_BREATH_LOW:  mirror_breath_low  = data[7:0];
            default: ;
        endcase
    endfunction

    function automatic alarm_result_t raise_into_table(input alarm_result_t r,
                                                       input logic [3:0] atype,
                                                       input logic [1:0] lvl,
                                                       input logic [7:0] val,
                                                       input logic [31:0] now);
        logic [31:0] win_s;
        int          slot;
        win_s = mirror_window_ms / 32'd1000;
        slot  = -1;
        if (atype == TYPE_NONE || atype > TYPE_MAX)
        begin
            r.status = STAT_INVALID;
            return r;
        end
        if (mirror_en_dedup)
        begin
            for (int i = 0; i < RECORDS; i++)
            begin
                if (mirror_type[i] == atype && mirror_state[i] == REC_TRIG &&
                    32'(now - mirror_time[i]) < win_s)
                begin
                    r.dedup_hit = 1'b1;
                    return r;
                end
            end
        end
        for (int i = 0; i < RECORDS; i++)
        begin
            if (slot < 0 && (mirror_state[i] == REC_IDLE || mirror_state[i] == REC_CLR))
                slot = i;
        end
        if (slot < 0)
        begin
            r.status = STAT_FULL;
            return r;
        end
        mirror_type[slot]  = atype;
        mirror_level[slot] = lvl;
        mirror_state[slot] = REC_TRIG;
        mirror_time[slot]  = now;
        mirror_value[slot] = val;
        mirror_triggered   = mirror_triggered + 32'd1;
        mirror_last_time   = now;
        if (mirror_en_local)
            mirror_local = 1'b1;
        r.raised       = 1'b1;
        r.raised_slot  = 8'(slot);
        r.raised_type  = atype;
        r.raised_level = lvl;
        r.raised_value = val;
        return r;
    endfunction

    function automatic alarm_result_t check_rate(input alarm_result_t r,
                                                 input logic [7:0] s,
                                                 input logic [7:0] hi,
                                                 input logic [7:0] lo,
                                                 input logic [3:0] type_hi,
                                                 input logic [3:0] type_lo,
                                                 input logic [31:0] now);
        if (s > hi)
            return raise_into_table(r, type_hi, LVL_WARN, s, now);
        if (s != 8'd0 && s < lo)
            return raise_into_table(r, type_lo, LVL_CRIT, s, now);
        return r;
    endfunction

    function automatic alarm_result_t predict_alarm_result(input alarm_word_t w);
        alarm_result_t r;
        r = '0;
        case (w.mode)
            MODE_HEART:
                r = check_rate(r, w.sample_value, mirror_heart_high, mirror_heart_low,
                               TYPE_HEART_HIGH, TYPE_HEART_LOW, w.now_seconds);
            MODE_BREATH:
                r = check_rate(r, w.sample_value, mirror_breath_high, mirror_breath_low,
                               TYPE_BREATH_HIGH, TYPE_BREATH_LOW, w.now_seconds);
            MODE_MOVE:
                if (w.sample_value == 8'd0)
                    r = raise_into_table(r, TYPE_NO_MOVE, LVL_WARN, 8'd0, w.now_seconds);
            MODE_TRIG:
                r = raise_into_table(r, w.trig_kind, w.trig_level, w.sample_value,
                                     w.now_seconds);
            MODE_ACK:
                if (w.alarm_index >= RECORDS)
                    r.status = STAT_INVALID;
                else if (mirror_state[w.alarm_index] == REC_TRIG)
                begin
                    mirror_state[w.alarm_index] = REC_ACK;
                    mirror_acknowledged = mirror_acknowledged + 32'd1;
                end
            MODE_CLR:
                if (w.alarm_index >= RECORDS)
                    r.status = STAT_INVALID;
                else if (mirror_state[w.alarm_index] != REC_CLR)
                begin
                    mirror_state[w.alarm_index] = REC_CLR;
                    mirror_cleared = mirror_cleared + 32'd1;
                end
            MODE_CLRALL:
                for (int i = 0; i < RECORDS; i++)
                begin
                    if (mirror_state[i] != REC_CLR)
                    begin
                        mirror_state[i] = REC_CLR;
                        mirror_cleared = mirror_cleared + 32'd1;
                    end
                end
            default:
                r.status = STAT_INVALID;
        endcase
        r.raised_time  = mirror_last_time;
        r.local_active = mirror_local;
        r.trig_total   = mirror_triggered;
        r.ack_total    = mirror_acknowledged;
        r.clear_total  = mirror_cleared;
        return r;
    endfunction

    function automatic logic [7:0] near_limit(input logic [7:0] hi, input logic [7:0] lo);
        case ($urandom_range(0, 6))
            0:       return 8'd0;
            1:       return lo - 8'd1;
            2:       return lo;
            3:       return hi;
            4:       return hi + 8'd1;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic alarm_word_t random_alarm_word();
        alarm_word_t w;
        int          pick;
        pick = $urandom_range(0, 99);
        case ($urandom_range(0, 19))
            0:       time_cursor = $urandom;
            1:       time_cursor = 32'hFFFF_FFFF - 32'($urandom_range(0, 60));
            default: time_cursor = time_cursor + 32'($urandom_range(0, 40));
        endcase
        w.mode         = 3'($urandom_range(0, 7));
        w.sample_value = 8'($urandom_range(0, 255));
        w.trig_kind    = 4'($urandom_range(0, 15));
        w.trig_level   = 2'($urandom_range(0, 3));
        w.alarm_index  = 8'($urandom_range(0, 255));
        w.now_seconds  = time_cursor;
        if (pick < 22)
        begin
            w.mode         = MODE_HEART;
            w.sample_value = near_limit(mirror_heart_high, mirror_heart_low);
        end
        else if (pick < 40)
        begin
            w.mode         = MODE_BREATH;
            w.sample_value = near_limit(mirror_breath_high, mirror_breath_low);
        end
        else if (pick < 50)
        begin
            w.mode = MODE_MOVE;
            if ($urandom_range(0, 1) == 0)
                w.sample_value = 8'd0;
        end
        else if (pick < 70)
        begin
            w.mode = MODE_TRIG;
            if ($urandom_range(0, 9) < 7)
                w.trig_kind = 4'($urandom_range(1, 8));
        end
        else if (pick < 90)
        begin
            w.mode = (pick < 80) ? MODE_ACK : MODE_CLR;
            if ($urandom_range(0, 9) < 8)
                w.alarm_index = 8'($urandom_range(0, RECORDS - 1));
        end
        else if (pick < 93)
            w.mode = MODE_CLRALL;
        else if (pick < 96)
            w.mode = MODE_UNUSED;
        return w;
    endfunction

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch on %s at %0t: want %0h got %0h", name, $time, want, got);
        end
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        set_mirror_register(idx, data);
        @(posedge clk);
    endtask

    task automatic program_registers(input logic en_local, input logic en_dedup,
                                     input logic [31:0] window_ms,
                                     input logic [7:0] heart_high, input logic [7:0] heart_low,
                                     input logic [7:0] breath_high, input logic [7:0] breath_low);
        write_register(CFG_EN_LOCAL, 32'(en_local));
        write_register(CFG_EN_DEDUP, 32'(en_dedup));
        write_register(CFG_WINDOW_MS, window_ms);
        write_register(CFG_HEART_HIGH, 32'(heart_high));
        write_register(CFG_HEART_LOW, 32'(heart_low));
        write_register(CFG_BREATH_HIGH, 32'(breath_high));
        write_register(CFG_BREATH_LOW, 32'(breath_low));
        cfg_we <= 1'b0;
    endtask

    task automatic pace_sender();
        if (burst_left == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
    endtask

    task automatic send_alarm_word(input alarm_word_t w);
        req_ch.valid        <= 1'b1;
        req_ch.mode         <= w.mode;
        req_ch.sample_value <= w.sample_value;
        req_ch.trig_kind    <= w.trig_kind;
        req_ch.trig_level   <= w.trig_level;
        req_ch.alarm_index  <= w.alarm_index;
        req_ch.now_seconds  <= w.now_seconds;
        @(posedge clk);
        while (req_ch.ready !== 1'b1)
            @(posedge clk);
        pending_alarm_results.push_back(predict_alarm_result(w));
        words_sent++;
    endtask

    task automatic drain_results();
        req_ch.valid <= 1'b0;
        burst_left = 0;
        while (pending_alarm_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // result checking and receiver stalls
    always @(posedge clk)
    begin : result_check
        alarm_result_t want;
        alarm_result_t got;
        if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            got.status       = rsp_ch.status;
            got.raised       = rsp_ch.raised;
            got.dedup_hit    = rsp_ch.dedup_hit;
            got.raised_slot  = rsp_ch.raised_slot;
            got.raised_type  = rsp_ch.raised_type;
            got.raised_level = rsp_ch.raised_level;
            got.raised_value = rsp_ch.raised_value;
            got.raised_time  = rsp_ch.raised_time;
            got.local_active = rsp_ch.local_active;
            got.trig_total   = rsp_ch.trig_total;
            got.ack_total    = rsp_ch.ack_total;
            got.clear_total  = rsp_ch.clear_total;
            if (pending_alarm_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result word with nothing pending at %0t", $time);
            end
            else
            begin
                want = pending_alarm_results.pop_front();
                results_seen++;
                raised_seen  += int'(want.raised);
                dedup_seen   += int'(want.dedup_hit);
                full_seen    += int'(want.status == STAT_FULL);
                invalid_seen += int'(want.status == STAT_INVALID);
                compare_field("status", 32'(want.status), 32'(got.status));
                compare_field("raised", 32'(want.raised), 32'(got.raised));
                compare_field("dedup_hit", 32'(want.dedup_hit), 32'(got.dedup_hit));
                compare_field("raised_slot", 32'(want.raised_slot), 32'(got.raised_slot));
                compare_field("raised_type", 32'(want.raised_type), 32'(got.raised_type));
                compare_field("raised_level", 32'(want.raised_level),
                              32'(got.raised_level));
                compare_field("raised_value", 32'(want.raised_value),
                              32'(got.raised_value));
                compare_field("raised_time", want.raised_time, got.raised_time);
                compare_field("local_active", 32'(want.local_active),
                              32'(got.local_active));
                compare_field("trig_total", want.trig_total, got.trig_total);
                compare_field("ack_total", want.ack_total, got.ack_total);
                compare_field("clear_total", want.clear_total, got.clear_total);
            end
        end
        if (stall_left == 0)
        begin
            stall_kind <= 2'($urandom_range(0, 3));
            stall_left <= $urandom_range(4, 40);
        end
        else
            stall_left <= stall_left - 1;
        case (stall_kind)
            2'd0:    rsp_ch.ready <= 1'b1;
            2'd1:    rsp_ch.ready <= ~rsp_ch.ready;
            2'd2:    rsp_ch.ready <= ($urandom_range(0, 9) < 3);
            default: rsp_ch.ready <= (stall_left[2:0] == 3'd0);
        endcase
    end

    // watchdog: cycles with no word moving on either channel
    always @(posedge clk)
    begin
        if (rst_n !== 1'b1 ||
            (req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
            (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog expired at %0t", $time);
            $display("FAILURE");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin : stimulus
        alarm_word_t   w;
        alarm_result_t typed_result;
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_idx             = '0;
        cfg_data            = '0;
        req_ch.valid        = 1'b0;
        req_ch.mode         = MODE_HEART;
        req_ch.sample_value = 8'd0;
        req_ch.trig_kind    = TYPE_NONE;
        req_ch.trig_level   = 2'd0;
        req_ch.alarm_index  = 8'd0;
        req_ch.now_seconds  = 32'd0;
        rsp_ch.ready        = 1'b0;
        reset_mirror();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        for (int n = 0; n < DIRECTED_ROWS; n++)
        begin
            w.mode         = directed_rows[n].mode;
            w.sample_value = directed_rows[n].sample_value;
            w.trig_kind    = directed_rows[n].trig_kind;
            w.trig_level   = directed_rows[n].trig_level;
            w.alarm_index  = directed_rows[n].alarm_index;
            w.now_seconds  = directed_rows[n].now_seconds;
            pace_sender();
            send_alarm_word(w);
            if (directed_rows[n].typed)
            begin
                typed_result           = pending_alarm_results.pop_back();
                typed_result.status    = directed_rows[n].status;
                typed_result.raised    = directed_rows[n].raised;
                typed_result.dedup_hit = directed_rows[n].dedup_hit;
                pending_alarm_results.push_back(typed_result);
            end
        end

        for (int p = 0; p < PHASES; p++)
        begin
            drain_results();
            case (p)
                0: program_registers(1'b1, 1'b1, 32'd60000, 8'd120, 8'd40, 8'd30, 8'd8);
                1: program_registers(1'b0, 1'b0, 32'd0, 8'd255, 8'd0, 8'd255, 8'd0);
                2: program_registers(1'b1, 1'b1, 32'hFFFF_FFFF, 8'd0, 8'd255, 8'd0, 8'd255);
                3: program_registers(1'b0, 1'b1, 32'd999, 8'd100, 8'd60, 8'd20, 8'd10);
                4: program_registers(1'b1, 1'b1, 32'd1000, 8'd140, 8'd50, 8'd25, 8'd12);
                default: program_registers(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                           32'($urandom_range(0, 200000)),
                                           8'($urandom_range(0, 255)),
                                           8'($urandom_range(0, 255)),
                                           8'($urandom_range(0, 255)),
                                           8'($urandom_range(0, 255)));
            endcase
            for (int k = 0; k < PHASE_WORDS; k++)
            begin
                pace_sender();
                send_alarm_word(random_alarm_word());
            end
        end

        drain_results();
        mismatches += pending_alarm_results.size();
        $display("covered %0d words over %0d register settings, %0d results checked",
                 words_sent, PHASES + 1, results_seen);
        $display("  %0d raised, %0d suppressed, %0d table full, %0d invalid",
                 raised_seen, dedup_seen, full_seen, invalid_seen);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
